@@ sv/hfbl_pkg.sv @@
// Shared types and constants for the haptic force budget limiter.
// Used by hfbl_sum, hfbl_lane and haptic_force_budget_limiter_unit.
`timescale 1ns / 1ps
package hfbl_pkg;

  // Finger count and field widths
  localparam int NumLanes = 5;
  localparam int ForceW   = 11;
  localparam int MagW     = ForceW - 1;
  localparam int BudgetW  = 13;
  localparam int SumW     = 13;
  localparam int ProdW    = MagW + BudgetW;
  localparam int AngleW   = 8;
  localparam int InDataW  = ((NumLanes * ForceW + 7) / 8) * 8;
  localparam int OutDataW = ((NumLanes * (AngleW + 1) + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CfgBudget = 1'b0,
    CfgFlip   = 1'b1
  } cfg_idx_e;

  localparam logic [BudgetW-1:0] BudgetReset = 13'd3000;

  // Angle map: angle = f*180/1000 = f*9/50, /50 done by reciprocal multiply
  localparam int AngleFull  = 180;
  localparam int AngleMul   = 9;
  localparam int AngleDiv   = 50;
  localparam int RecipShift = 19;
  localparam int RecipMul   = ((1 << RecipShift) + AngleDiv - 1) / AngleDiv;
  localparam int XW         = 14;
  localparam int RecipW     = 27;

  // Pipeline stage map
  localparam int DivStages = MagW;
  localparam int StgIn     = 0;
  localparam int StgProd   = 1;
  localparam int StgDiv0   = 2;
  localparam int StgRecip  = StgDiv0 + DivStages;
  localparam int StgOut    = StgRecip + 1;
  localparam int NumStages = StgOut + 1;

  // Frame-wide scaling info sent from the summing stage to every lane
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            scale;
  } scale_t;

endpackage

@@ sv/haptic_force_budget_limiter_unit.sv @@
// Haptic force budget limiter top level: stream ports, config registers,
// stage handshake chain, five hfbl_lane instances and the hfbl_sum merge.
`timescale 1ns / 1ps
// One frame of five finger forces enters per beat and one beat of five servo
// angles with drive flags leaves for each frame; with the output free the block
// takes a new frame every cycle. Each frame passes through capture, product,
// the per-lane quotient pipeline (one quotient bit per stage, ten stages),
// reciprocal and output stages. Each stage only waits when it holds a frame
// and the stage after it is stalled, so bubbles close up under backpressure.
// force_budget and flip_direction reset to 3000 and 0; the user must write them
// through the cfg port only while no frame is in flight, which is not enforced.
module haptic_force_budget_limiter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: force_thumb, force_index, force_middle, force_ring, force_pinky
  input  logic [hfbl_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: angle_thumb, angle_index, angle_middle, angle_ring, angle_pinky,
  //        drive_thumb, drive_index, drive_middle, drive_ring, drive_pinky
  output logic [hfbl_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic                           cfg_we_i,
  input  logic [hfbl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hfbl_pkg::BudgetW-1:0]   cfg_wdata_i
);

  localparam int NS = hfbl_pkg::NumStages;
  localparam int NL = hfbl_pkg::NumLanes;

  // Configuration registers
  logic [hfbl_pkg::BudgetW-1:0] budget_q;
  logic                         flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= hfbl_pkg::BudgetReset;
      flip_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (hfbl_pkg::cfg_idx_e'(cfg_idx_i))
        hfbl_pkg::CfgBudget: budget_q <= cfg_wdata_i;
        hfbl_pkg::CfgFlip:   flip_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stage occupancy and advance chain
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = ~vld_q[NS-1] | m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NS-1];

  // Lanes and the frame-wide merge
  logic [NL-1:0][hfbl_pkg::MagW-1:0]   force0;
  logic [NL-1:0][hfbl_pkg::AngleW-1:0] angle;
  logic [NL-1:0]                       drive;
  hfbl_pkg::scale_t                    scale;

  hfbl_sum u_sum (
    .clk_i    (clk_i),
    .en_i     (en[hfbl_pkg::StgProd]),
    .force_i  (force0),
    .budget_i (budget_q),
    .scale_o  (scale)
  );

  for (genvar i = 0; i < NL; i++) begin : g_lane
    hfbl_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .force_i  (s_axis_tdata_i[i*hfbl_pkg::ForceW +: hfbl_pkg::ForceW]),
      .force0_o (force0[i]),
      .scale_i  (scale),
      .budget_i (budget_q),
      .flip_i   (flip_q),
      .angle_o  (angle[i]),
      .drive_o  (drive[i])
    );
  end

  // Output packing: angles low, drive flags above, zero fill on top
  assign m_axis_tdata_o = hfbl_pkg::OutDataW'({drive, angle});

  // Checks
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output stage");

  a_ready_when_sink_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while the sink takes beats");

  for (genvar i = 0; i < NL; i++) begin : g_chk
    a_idle_angle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && !drive[i]) |-> (angle[i] == '0))
      else $error("undriven finger carries a nonzero angle");
  end

endmodule

@@ sv/hfbl_sum.sv @@
// Merging stage: sums the valid finger forces of one frame and flags scaling.
// Depends on hfbl_pkg.
`timescale 1ns / 1ps
module hfbl_sum (
  input  logic                                              clk_i,
  input  logic                                              en_i,
  input  logic [hfbl_pkg::NumLanes-1:0][hfbl_pkg::MagW-1:0] force_i,
  input  logic [hfbl_pkg::BudgetW-1:0]                      budget_i,
  output hfbl_pkg::scale_t                                  scale_o
);

  logic [hfbl_pkg::SumW-1:0] sum;
  hfbl_pkg::scale_t          scale_d, scale_q;

  // Forces of missing requests arrive already zeroed
  always_comb begin
    sum = '0;
    for (int i = 0; i < hfbl_pkg::NumLanes; i++) begin
      sum = sum + hfbl_pkg::SumW'(force_i[i]);
    end
    scale_d.sum   = sum;
    scale_d.scale = (sum > budget_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scale_q <= scale_d;
    end
  end

  assign scale_o = scale_q;

endmodule

@@ sv/hfbl_lane.sv @@
// One finger lane: input capture, force*budget product, bit-per-stage
// quotient pipeline, and the force-to-angle map. Depends on hfbl_pkg.
`timescale 1ns / 1ps
module hfbl_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [hfbl_pkg::NumStages-1:0]      en_i,
  input  logic [hfbl_pkg::ForceW-1:0]         force_i,
  output logic [hfbl_pkg::MagW-1:0]           force0_o,
  input  hfbl_pkg::scale_t                    scale_i,
  input  logic [hfbl_pkg::BudgetW-1:0]        budget_i,
  input  logic                                flip_i,
  output logic [hfbl_pkg::AngleW-1:0]         angle_o,
  output logic                                drive_o
);

  localparam int DS = hfbl_pkg::DivStages;

  // Stage 0: capture, mask missing requests
  logic [hfbl_pkg::MagW-1:0] f0_q;
  logic                      vld0_q;

  always_ff @(posedge clk_i) begin
    if (en_i[hfbl_pkg::StgIn]) begin
      vld0_q <= ~force_i[hfbl_pkg::ForceW-1];
      f0_q   <= force_i[hfbl_pkg::ForceW-1] ? '0 : force_i[hfbl_pkg::MagW-1:0];
    end
  end

  assign force0_o = f0_q;

  // Stage 1: dividend force*budget
  logic [hfbl_pkg::ProdW-1:0] prod1_q;
  logic [hfbl_pkg::MagW-1:0]  f1_q;
  logic                       vld1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[hfbl_pkg::StgProd]) begin
      prod1_q <= hfbl_pkg::ProdW'(f0_q) * hfbl_pkg::ProdW'(budget_i);
      f1_q    <= f0_q;
      vld1_q  <= vld0_q;
    end
  end

  // Quotient pipeline: one quotient bit per stage, MSB first
  logic [hfbl_pkg::ProdW-1:0] rem_in  [DS];
  logic [hfbl_pkg::MagW-1:0]  quo_in  [DS];
  logic [hfbl_pkg::SumW-1:0]  den_in  [DS];
  logic                       sc_in   [DS];
  logic [hfbl_pkg::MagW-1:0]  f_in    [DS];
  logic                       vld_in  [DS];
  logic [hfbl_pkg::ProdW-1:0] rem_q   [DS];
  logic [hfbl_pkg::MagW-1:0]  quo_q   [DS];
  logic [hfbl_pkg::SumW-1:0]  den_q   [DS];
  logic                       sc_q    [DS];
  logic [hfbl_pkg::MagW-1:0]  f_q     [DS];
  logic                       vld_q   [DS];

  for (genvar i = 0; i < DS; i++) begin : g_div
    localparam int K = DS - 1 - i;
    logic [hfbl_pkg::ProdW-1:0] dsh;
    logic                       fits;

    if (i == 0) begin : g_first
      assign rem_in[i] = prod1_q;
      assign quo_in[i] = '0;
      assign den_in[i] = scale_i.sum;
      assign sc_in[i]  = scale_i.scale;
      assign f_in[i]   = f1_q;
      assign vld_in[i] = vld1_q;
    end else begin : g_next
      assign rem_in[i] = rem_q[i-1];
      assign quo_in[i] = quo_q[i-1];
      assign den_in[i] = den_q[i-1];
      assign sc_in[i]  = sc_q[i-1];
      assign f_in[i]   = f_q[i-1];
      assign vld_in[i] = vld_q[i-1];
    end

    assign dsh  = hfbl_pkg::ProdW'(den_in[i]) << K;
    assign fits = (rem_in[i] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i[hfbl_pkg::StgDiv0 + i]) begin
        rem_q[i]    <= fits ? (rem_in[i] - dsh) : rem_in[i];
        quo_q[i]    <= quo_in[i] | (hfbl_pkg::MagW'(fits) << K);
        den_q[i]    <= den_in[i];
        sc_q[i]     <= sc_in[i];
        f_q[i]      <= f_in[i];
        vld_q[i]    <= vld_in[i];
      end
    end
  end

  // Reciprocal stage: x = f*9, m = x * ceil(2^19/50)
  logic [hfbl_pkg::MagW-1:0]   fsafe;
  logic [hfbl_pkg::XW-1:0]     x_d, x_q;
  logic [hfbl_pkg::RecipW-1:0] m_q;
  logic                        vldr_q;

  assign fsafe = sc_q[DS-1] ? quo_q[DS-1] : f_q[DS-1];
  assign x_d   = hfbl_pkg::XW'(fsafe) * hfbl_pkg::XW'(hfbl_pkg::AngleMul);

  always_ff @(posedge clk_i) begin
    if (en_i[hfbl_pkg::StgRecip]) begin
      x_q    <= x_d;
      m_q    <= hfbl_pkg::RecipW'(x_d) * hfbl_pkg::RecipW'(hfbl_pkg::RecipMul);
      vldr_q <= vld_q[DS-1];
    end
  end

  // Output stage: floor or ceiling quotient, then the angle map
  logic [hfbl_pkg::AngleW-1:0] qf;
  logic [hfbl_pkg::XW-1:0]     rmd;
  logic [hfbl_pkg::AngleW:0]   qc;
  logic [hfbl_pkg::AngleW-1:0] angle_d, angle_q;
  logic                        drive_q;

  always_comb begin
    qf  = m_q[hfbl_pkg::RecipShift +: hfbl_pkg::AngleW];
    rmd = x_q - hfbl_pkg::XW'(qf) * hfbl_pkg::XW'(hfbl_pkg::AngleDiv);
    qc  = (hfbl_pkg::AngleW+1)'(qf) + (hfbl_pkg::AngleW+1)'(rmd != '0);
    if (!vldr_q) begin
      angle_d = '0;
    end else if (flip_i) begin
      angle_d = (qf > hfbl_pkg::AngleW'(hfbl_pkg::AngleFull))
                ? hfbl_pkg::AngleW'(hfbl_pkg::AngleFull) : qf;
    end else if (qc > (hfbl_pkg::AngleW+1)'(hfbl_pkg::AngleFull)) begin
      angle_d = '0;
    end else begin
      angle_d = hfbl_pkg::AngleW'((hfbl_pkg::AngleW+1)'(hfbl_pkg::AngleFull) - qc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      drive_q <= 1'b0;
    end else if (en_i[hfbl_pkg::StgOut]) begin
      angle_q <= angle_d;
      drive_q <= vldr_q;
    end
  end

  assign angle_o = angle_q;
  assign drive_o = drive_q;

endmodule

@@ tb/tb_haptic_force_budget_limiter_unit.sv @@
// Self-checking bench for haptic_force_budget_limiter_unit: stream frames of five
// finger forces in, servo angle beats out, checked against an in-bench predictor.
// Depends on hfbl_pkg and the RTL of the unit only.
`timescale 1ns / 1ps
module tb_haptic_force_budget_limiter_unit;
  import hfbl_pkg::*;

  typedef logic [NumLanes-1:0][ForceW-1:0] forces_t;
  typedef logic [OutDataW-1:0] servo_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // tdata: force_thumb, force_index, force_middle, force_ring, force_pinky
  logic [InDataW-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // tdata: angle_thumb .. angle_pinky, drive_thumb .. drive_pinky
  logic [OutDataW-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CfgBudget;
  logic [BudgetW-1:0] cfg_wdata = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  haptic_force_budget_limiter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // Predicts servo beats from force frames and checks them in order
  class servo_scoreboard;
    logic [BudgetW-1:0] budget;
    logic flip;
    servo_beat_t angles_q[$];
    int errors;
    string lane_name[NumLanes] = '{"thumb", "index", "middle", "ring", "pinky"};

    function new();
      budget = BudgetReset;
      flip = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [BudgetW-1:0] value);
      if (idx == CfgBudget) budget = value;
      else flip = value[0];
    endfunction

    function int pending();
      return angles_q.size();
    endfunction

    // Force to whole-degree angle, exact rational ceil/floor with saturation
    function logic [AngleW-1:0] angle_of(int unsigned f);
      int unsigned prod;
      int unsigned q;
      prod = f * 180;
      if (flip) begin
        q = prod / 1000;
        return (q > 180) ? AngleW'(180) : AngleW'(q);
      end
      q = (prod + 999) / 1000;
      return (q > 180) ? AngleW'(0) : AngleW'(180 - q);
    endfunction

    // Accepted frame: sum valid requests, scale down if over budget, map
    function void note_frame(forces_t f);
      int unsigned force_mag[NumLanes];
      logic valid[NumLanes];
      int unsigned sum;
      int unsigned g;
      servo_beat_t beat;
      sum = 0;
      beat = '0;
      for (int i = 0; i < NumLanes; i++) begin
        valid[i] = !f[i][ForceW-1];
        force_mag[i] = valid[i] ? int'(f[i][MagW-1:0]) : 0;
        sum += force_mag[i];
      end
      for (int i = 0; i < NumLanes; i++) begin
        if (valid[i]) begin
          g = force_mag[i];
          if (sum > budget) g = (g * budget) / sum;
          beat[i*AngleW +: AngleW] = angle_of(g);
          beat[NumLanes*AngleW + i] = 1'b1;
        end
      end
      angles_q.push_back(beat);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_beat(servo_beat_t got);
      servo_beat_t want;
      if (angles_q.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
        return;
      end
      want = angles_q.pop_front();
      for (int i = 0; i < NumLanes; i++) begin
        if (got[i*AngleW +: AngleW] !== want[i*AngleW +: AngleW])
          report($sformatf("angle_%s got %0d want %0d", lane_name[i],
                           got[i*AngleW +: AngleW], want[i*AngleW +: AngleW]));
        if (got[NumLanes*AngleW + i] !== want[NumLanes*AngleW + i])
          report($sformatf("drive_%s got %b want %b", lane_name[i],
                           got[NumLanes*AngleW + i], want[NumLanes*AngleW + i]));
      end
    endtask
  endclass

  servo_scoreboard sb = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Output side: random stalls, check every accepted beat
  initial begin
    forever begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk_i);
      if (rst_ni && m_tvalid === 1'b1 && m_tready) sb.check_beat(m_tdata);
    end
  end

  function automatic forces_t frame_of(int a, int b, int c, int d, int e);
    forces_t f;
    f[0] = ForceW'(a);
    f[1] = ForceW'(b);
    f[2] = ForceW'(c);
    f[3] = ForceW'(d);
    f[4] = ForceW'(e);
    return f;
  endfunction

  // Mostly real requests, with no-request codes, overrange and round values mixed in
  function automatic logic [ForceW-1:0] rand_force();
    int r;
    r = $urandom_range(99);
    if (r < 8) return {1'b1, MagW'($urandom)};
    if (r < 12) return '1;
    if (r < 18) return ForceW'($urandom_range(1023, 1001));
    if (r < 23) return '0;
    if (r < 28) return ForceW'(1000);
    if (r < 36) return ForceW'(50 * $urandom_range(20));
    if (r < 44) return ForceW'($urandom_range(60));
    return ForceW'($urandom_range(1000));
  endfunction

  task automatic push_frame(forces_t f);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= InDataW'(f);
    do @(posedge clk_i); while (s_tready !== 1'b1);
    sb.note_frame(f);
  endtask

  // Let the pipeline empty before touching the registers
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic load_limits(logic [BudgetW-1:0] budget, logic flip);
    cfg_we <= 1'b1;
    cfg_idx <= CfgBudget;
    cfg_wdata <= budget;
    @(posedge clk_i);
    sb.set_reg(CfgBudget, budget);
    cfg_idx <= CfgFlip;
    cfg_wdata <= BudgetW'(flip);
    @(posedge clk_i);
    sb.set_reg(CfgFlip, BudgetW'(flip));
    cfg_we <= 1'b0;
  endtask

  task automatic run_segment(int budget, int flip, int count);
    forces_t f;
    settle();
    load_limits(BudgetW'(budget), flip[0]);
    repeat (count) begin
      for (int i = 0; i < NumLanes; i++) f[i] = rand_force();
      push_frame(f);
    end
  endtask

  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Phase 1: light sender gaps, heavy output stalls
    tx_idle_pct = 16;
    rx_idle_pct = 62;
    // Directed frames at reset limits (budget 3000, normal direction)
    push_frame(frame_of(-1, -1, -1, -1, -1));          // no requests, zero sum
    push_frame(frame_of(0, 0, 0, 0, 0));               // valid but zero sum
    push_frame(frame_of(1000, 1000, 1000, 1000, 1000)); // over budget
    push_frame(frame_of(1023, 1023, 1023, 1023, 1023)); // overrange forces
    push_frame(frame_of(-1024, -1024, -1024, -1024, -1024));
    push_frame(frame_of(600, 600, 600, 600, 600));     // sum equals budget
    push_frame(frame_of(600, 600, 600, 600, 601));     // one over budget
    push_frame(frame_of(1000, -1, -1, -1, -1));
    push_frame(frame_of(1001, 1, -1, 0, 999));
    push_frame(frame_of(1, 2, 3, 4, 5));
    push_frame(frame_of(1023, -1024, 1000, -1, 0));
    push_frame(frame_of(-2, 1000, 1000, 1000, 1));
    push_frame(frame_of(5, 6, 994, 995, 999));
    push_frame(frame_of(500, 250, 125, 750, 1000));
    push_frame(frame_of(1000, 1000, 1000, 0, 0));
    push_frame(frame_of(1000, 1000, 1000, 1, 0));
    push_frame(frame_of(50, 100, 550, 1000, 950));
    push_frame(frame_of(682, 341, 1023, -513, 170));

    run_segment(0, 1, 150);
    run_segment(5000, 0, 150);
    run_segment(1, 1, 150);

    // Phase 2: heavy sender gaps, light output stalls
    settle();
    tx_idle_pct = 62;
    rx_idle_pct = 16;
    run_segment(8191, 0, 150);
    run_segment(3000, 1, 150);
    run_segment($urandom_range(5000), 0, 200);

    // Phase 3: full rate both ways
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_segment(2500, 1, 200);
    run_segment($urandom_range(5000), $urandom_range(1), 200);
    run_segment(1500, 0, 200);

    settle();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/hfbl_pkg.sv
sv/hfbl_sum.sv
sv/hfbl_lane.sv
sv/haptic_force_budget_limiter_unit.sv
tb/tb_haptic_force_budget_limiter_unit.sv
